// ===== rtl/core/mctp_rx_pkg.sv =====
// ----------------------------------------------------------------------------
// MCTP receive reassembly package
// Shared constants, transaction mode and status codes, and the command and
// status groups exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package mctp_rx_pkg;

  // Message store and packet buffer geometry.
  localparam int MsgBytes = 4096;
  localparam int MsgAw    = 12;
  localparam int MsgLenW  = 13;
  localparam int PktMtu   = 68;
  localparam int PktAw    = 7;
  localparam int HdrBytes = 4;

  // SMBus command code that opens an MCTP packet.
  localparam logic [7:0] CmdMctp = 8'h0F;

  // Input transaction modes.
  localparam logic [1:0] ModeStart  = 2'd0;
  localparam logic [1:0] ModeByte   = 2'd1;
  localparam logic [1:0] ModeFinish = 2'd2;
  localparam logic [1:0] ModeRead   = 2'd3;

  // Result status codes.
  localparam logic [2:0] StNone     = 3'd0;
  localparam logic [2:0] StFragment = 3'd1;
  localparam logic [2:0] StComplete = 3'd2;
  localparam logic [2:0] StOversize = 3'd3;
  localparam logic [2:0] StTruncate = 3'd4;
  localparam logic [2:0] StSeqError = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // input transaction accepted this cycle
    logic copy;      // copy sequencer is running
    logic copy_end;  // copy finished, commit length and flags
    logic load_out;  // capture the result registers
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic copy_go;    // accepted finish passed its checks
    logic copy_done;  // all payload bytes written to the store
  } dp_stat_t;

endpackage

// ===== rtl/core/mctp_rx_datapath.sv =====
// ----------------------------------------------------------------------------
// MCTP receive reassembly datapath
// Byte parser, packet checks, payload buffer, message store, copy sequencer
// and result registers.
// ----------------------------------------------------------------------------
module mctp_rx_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mctp_rx_pkg::dp_cmd_t               cmd_i,
  output mctp_rx_pkg::dp_stat_t              stat_o,
  input  logic [1:0]                         mode_i,
  input  logic [7:0]                         data_byte_i,
  input  logic [mctp_rx_pkg::MsgAw-1:0]      read_index_i,
  output logic [2:0]                         status_o,
  output logic [mctp_rx_pkg::MsgLenW-1:0]    message_length_o,
  output logic [7:0]                         peer_endpoint_o,
  output logic [2:0]                         message_tag_o,
  output logic [7:0]                         read_data_o,
  output logic                               in_progress_o
);

  localparam logic [2:0] PhCmd  = 3'd0;
  localparam logic [2:0] PhBcnt = 3'd1;
  localparam logic [2:0] PhSrc  = 3'd2;
  localparam logic [2:0] PhHdr  = 3'd3;
  localparam logic [2:0] PhPay  = 3'd4;

  localparam logic [7:0] MaxBcnt = 8'(5 + mctp_rx_pkg::PktMtu);
  localparam logic [mctp_rx_pkg::MsgLenW-1:0] StoreSize =
    mctp_rx_pkg::MsgLenW'(mctp_rx_pkg::MsgBytes);

  logic [2:0]                          phase_q, phase_d;
  logic signed [8:0]                   promised_q, promised_d;
  logic [2:0]                          hdr_cnt_q, hdr_cnt_d;
  logic [mctp_rx_pkg::PktAw-1:0]       pay_cnt_q, pay_cnt_d;
  logic                                too_large_q, too_large_d;
  logic [mctp_rx_pkg::MsgLenW-1:0]     stored_len_q, stored_len_d;
  logic [1:0]                          exp_seq_q, exp_seq_d;
  logic [2:0]                          tag_q, tag_d;
  logic [7:0]                          peer_q, peer_d;
  logic                                assembling_q, assembling_d;
  logic [2:0]                          status_q, status_d;
  logic                                eom_q, eom_d;
  logic [mctp_rx_pkg::PktAw-1:0]       copy_len_q, copy_len_d;
  logic [mctp_rx_pkg::PktAw-1:0]       rd_cnt_q, rd_cnt_d;
  logic                                pend_q, pend_d;
  logic [mctp_rx_pkg::MsgAw-1:0]       wr_addr_q, wr_addr_d;
  logic                                is_read_q, is_read_d;

  logic [7:0] hdr_q [mctp_rx_pkg::HdrBytes];
  logic [7:0] pkt_mem [mctp_rx_pkg::PktMtu];
  logic [7:0] store_mem [mctp_rx_pkg::MsgBytes];
  logic [7:0] pkt_rd_q;
  logic [7:0] store_rd_q;

  logic [7:0] flags;
  logic       som, eom, seq_bad, trunc, finish, copy_go;
  logic       hdr_wr, pay_wr, copy_rd;
  logic [mctp_rx_pkg::MsgLenW-1:0] space;
  logic [mctp_rx_pkg::PktAw-1:0]   copy_n;

  assign flags   = hdr_q[3];
  assign som     = flags[7];
  assign eom     = flags[6];
  assign seq_bad = !som && (!assembling_q || (flags[5:4] != exp_seq_q));
  assign trunc   = $signed({2'b00, pay_cnt_q}) < promised_q;
  assign finish  = cmd_i.take && (mode_i == mctp_rx_pkg::ModeFinish) &&
                   (hdr_cnt_q == 3'(mctp_rx_pkg::HdrBytes));
  assign copy_go = finish && !too_large_q && !trunc && !seq_bad;

  // A start packet empties the store before its payload is appended.
  assign space  = som ? StoreSize : (StoreSize - stored_len_q);
  assign copy_n = ({6'd0, pay_cnt_q} < space) ? pay_cnt_q
                                              : space[mctp_rx_pkg::PktAw-1:0];

  assign hdr_wr  = cmd_i.take && (mode_i == mctp_rx_pkg::ModeByte) &&
                   (phase_q == PhHdr) && (hdr_cnt_q < 3'(mctp_rx_pkg::HdrBytes));
  assign pay_wr  = cmd_i.take && (mode_i == mctp_rx_pkg::ModeByte) &&
                   (phase_q == PhPay) &&
                   (pay_cnt_q < mctp_rx_pkg::PktAw'(mctp_rx_pkg::PktMtu));
  assign copy_rd = cmd_i.copy && (rd_cnt_q < copy_len_q);

  assign stat_o.copy_go   = copy_go;
  assign stat_o.copy_done = (rd_cnt_q == copy_len_q) && !pend_q;

  always_comb begin
    phase_d      = phase_q;
    promised_d   = promised_q;
    hdr_cnt_d    = hdr_cnt_q;
    pay_cnt_d    = pay_cnt_q;
    too_large_d  = too_large_q;
    stored_len_d = stored_len_q;
    exp_seq_d    = exp_seq_q;
    tag_d        = tag_q;
    peer_d       = peer_q;
    assembling_d = assembling_q;
    status_d     = status_q;
    eom_d        = eom_q;
    copy_len_d   = copy_len_q;
    rd_cnt_d     = rd_cnt_q;
    pend_d       = 1'b0;
    wr_addr_d    = wr_addr_q;
    is_read_d    = is_read_q;

    if (cmd_i.take) begin
      status_d  = mctp_rx_pkg::StNone;
      is_read_d = (mode_i == mctp_rx_pkg::ModeRead);
      case (mode_i)
        mctp_rx_pkg::ModeStart: begin
          phase_d     = PhCmd;
          hdr_cnt_d   = '0;
          pay_cnt_d   = '0;
          too_large_d = 1'b0;
        end
        mctp_rx_pkg::ModeByte: begin
          unique case (phase_q)
            PhCmd: begin
              if (data_byte_i == mctp_rx_pkg::CmdMctp) begin
                phase_d = PhBcnt;
              end
            end
            PhBcnt: begin
              promised_d = $signed({1'b0, data_byte_i}) - 9'sd5;
              if (data_byte_i > MaxBcnt) begin
                too_large_d = 1'b1;
              end
              phase_d = PhSrc;
            end
            PhSrc: begin
              phase_d = PhHdr;
            end
            PhHdr: begin
              // A header byte beyond the fourth is dropped, but still ends the header.
              if (hdr_wr) begin
                hdr_cnt_d = hdr_cnt_q + 3'd1;
              end
              if (hdr_cnt_d >= 3'(mctp_rx_pkg::HdrBytes)) begin
                phase_d = (promised_q > 9'sd0) ? PhPay : PhCmd;
              end
            end
            PhPay: begin
              if (pay_wr) begin
                pay_cnt_d = pay_cnt_q + 7'd1;
              end
            end
            default: begin
              phase_d = PhCmd;
            end
          endcase
        end
        mctp_rx_pkg::ModeFinish: begin
          phase_d = PhCmd;
          if (finish) begin
            hdr_cnt_d  = '0;
            pay_cnt_d  = '0;
            promised_d = '0;
            if (too_large_q) begin
              assembling_d = 1'b0;
              status_d     = mctp_rx_pkg::StOversize;
            end else if (trunc) begin
              assembling_d = 1'b0;
              status_d     = mctp_rx_pkg::StTruncate;
            end else if (seq_bad) begin
              assembling_d = 1'b0;
              status_d     = mctp_rx_pkg::StSeqError;
            end else begin
              if (som) begin
                stored_len_d = '0;
                exp_seq_d    = '0;
                assembling_d = 1'b1;
                peer_d       = hdr_q[2];
                tag_d        = flags[2:0];
              end
              eom_d      = eom;
              copy_len_d = copy_n;
              rd_cnt_d   = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (copy_rd) begin
      rd_cnt_d  = rd_cnt_q + 7'd1;
      pend_d    = 1'b1;
      wr_addr_d = stored_len_q[mctp_rx_pkg::MsgAw-1:0] + {5'd0, rd_cnt_q};
    end

    if (cmd_i.copy_end) begin
      stored_len_d = stored_len_q + {6'd0, copy_len_q};
      exp_seq_d    = exp_seq_q + 2'd1;
      if (eom_q) begin
        assembling_d = 1'b0;
        status_d     = mctp_rx_pkg::StComplete;
      end else begin
        status_d     = mctp_rx_pkg::StFragment;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhCmd;
      promised_q   <= '0;
      hdr_cnt_q    <= '0;
      pay_cnt_q    <= '0;
      too_large_q  <= 1'b0;
      stored_len_q <= '0;
      exp_seq_q    <= '0;
      tag_q        <= '0;
      peer_q       <= '0;
      assembling_q <= 1'b0;
      status_q     <= mctp_rx_pkg::StNone;
      eom_q        <= 1'b0;
      copy_len_q   <= '0;
      rd_cnt_q     <= '0;
      pend_q       <= 1'b0;
      is_read_q    <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      promised_q   <= promised_d;
      hdr_cnt_q    <= hdr_cnt_d;
      pay_cnt_q    <= pay_cnt_d;
      too_large_q  <= too_large_d;
      stored_len_q <= stored_len_d;
      exp_seq_q    <= exp_seq_d;
      tag_q        <= tag_d;
      peer_q       <= peer_d;
      assembling_q <= assembling_d;
      status_q     <= status_d;
      eom_q        <= eom_d;
      copy_len_q   <= copy_len_d;
      rd_cnt_q     <= rd_cnt_d;
      pend_q       <= pend_d;
      is_read_q    <= is_read_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    if (hdr_wr) begin
      hdr_q[hdr_cnt_q[1:0]] <= data_byte_i;
    end
  end

  // Packet payload buffer: written by the parser, read by the copy sequencer.
  always_ff @(posedge clk_i) begin
    if (pay_wr) begin
      pkt_mem[pay_cnt_q] <= data_byte_i;
    end
    if (copy_rd) begin
      pkt_rd_q <= pkt_mem[rd_cnt_q];
    end
  end

  // Message store: written by the copy sequencer, read by read transactions.
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      store_mem[wr_addr_q] <= pkt_rd_q;
    end
    if (cmd_i.take && (mode_i == mctp_rx_pkg::ModeRead)) begin
      store_rd_q <= store_mem[read_index_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o         <= status_q;
      message_length_o <= stored_len_q;
      peer_endpoint_o  <= peer_q;
      message_tag_o    <= tag_q;
      read_data_o      <= is_read_q ? store_rd_q : 8'd0;
      in_progress_o    <= assembling_q;
    end
  end

endmodule

// ===== rtl/core/mctp_rx_ctrl.sv =====
// ----------------------------------------------------------------------------
// MCTP receive reassembly controller
// Handshake control and sequencing of the payload copy and result capture.
// ----------------------------------------------------------------------------
module mctp_rx_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output mctp_rx_pkg::dp_cmd_t   cmd_o,
  input  mctp_rx_pkg::dp_stat_t  stat_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCopy = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       take;

  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign cmd_o.take     = take;
  assign cmd_o.copy     = (state_q == StCopy);
  assign cmd_o.copy_end = (state_q == StCopy) && stat_i.copy_done;
  assign cmd_o.load_out = (state_q == StDone);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (take) begin
          state_d = stat_i.copy_go ? StCopy : StDone;
        end
      end
      StCopy: begin
        if (stat_i.copy_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        out_valid_d = 1'b1;
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/mctp_smbus_rx_reassembly_core.sv =====
// ----------------------------------------------------------------------------
// MCTP over SMBus receive reassembly core
// Parses SMBus write transfers into MCTP packets and reassembles messages.
// ----------------------------------------------------------------------------
// Each input transaction carries one bus event: start of a write transfer, one
// written byte, transfer finish, or a read of one message store byte. Every
// transaction yields exactly one result transaction carrying the finish status
// and the current message length, peer endpoint, tag and assembling flag. A
// start, byte or read transaction, and a finish that fails its checks or finds
// only a partial header, goes from acceptance straight to result capture. A
// finish that passes its checks runs the copy sequencer, which moves the
// packet payload from the 68-byte packet buffer into the 4096-byte message
// store one byte per cycle through the single write port of the store; such a
// finish captures its result once every appended byte is in the store. One
// transaction is in flight at a time, and the next is accepted as soon as the
// block is idle and the previous result has been taken or is being taken in
// the same cycle. Reading a store position that was never written returns an
// undefined byte.

module mctp_smbus_rx_reassembly_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         mode_i,
  input  logic [7:0]                         data_byte_i,
  input  logic [mctp_rx_pkg::MsgAw-1:0]      read_index_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [2:0]                         status_o,
  output logic [mctp_rx_pkg::MsgLenW-1:0]    message_length_o,
  output logic [7:0]                         peer_endpoint_o,
  output logic [2:0]                         message_tag_o,
  output logic [7:0]                         read_data_o,
  output logic                               in_progress_o
);

  // Command and status groups between the controller and the datapath.
  mctp_rx_pkg::dp_cmd_t  dp_cmd;
  mctp_rx_pkg::dp_stat_t dp_stat;

  // The controller owns both handshakes and sequences the copy.
  mctp_rx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  // The datapath holds the parser, both memories and the result registers.
  mctp_rx_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .stat_o           (dp_stat),
    .mode_i           (mode_i),
    .data_byte_i      (data_byte_i),
    .read_index_i     (read_index_i),
    .status_o         (status_o),
    .message_length_o (message_length_o),
    .peer_endpoint_o  (peer_endpoint_o),
    .message_tag_o    (message_tag_o),
    .read_data_o      (read_data_o),
    .in_progress_o    (in_progress_o)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MCTP over SMBus receive reassembly core testbench
// Drives bus events (write start, written bytes, finish, store reads) through
// the valid/ready input channel. A scoreboard predicts every result from its
// own copy of the parser, packet buffer and message store, and checks each
// result transaction field by field. Both channels idle at random, and the
// receiver holds off once for a long stretch to stall the input.
// ----------------------------------------------------------------------------
module testbench;
  import mctp_rx_pkg::*;

  typedef enum logic [2:0] {
    PhCommand,
    PhByteCount,
    PhSource,
    PhHeader,
    PhPayload
  } parse_phase_e;

  typedef struct packed {
    logic [2:0]         status;
    logic [MsgLenW-1:0] length;
    logic [7:0]         peer;
    logic [2:0]         tag;
    logic [7:0]         rdata;
    logic               busy;
  } reassembly_result_t;

  // Scoreboard: tracks the packet parser and message store and queues the
  // result that each accepted transaction should produce.
  class reassembly_scoreboard;
    parse_phase_e       phase;
    int                 promised;
    logic [7:0]         hdr [HdrBytes];
    int                 hdr_cnt;
    logic [7:0]         packet_buf [PktMtu];
    int                 pay_cnt;
    bit                 too_large;
    logic [7:0]         store [MsgBytes];
    int                 stored_len;
    int                 written_top;
    logic [1:0]         exp_seq;
    logic [2:0]         held_tag;
    logic [7:0]         held_peer;
    bit                 assembling;
    int                 errors;
    reassembly_result_t pending_results [$];

    function new();
      phase       = PhCommand;
      promised    = 0;
      hdr_cnt     = 0;
      pay_cnt     = 0;
      too_large   = 1'b0;
      stored_len  = 0;
      written_top = 0;
      exp_seq     = 2'd0;
      held_tag    = 3'd0;
      held_peer   = 8'd0;
      assembling  = 1'b0;
      errors      = 0;
    endfunction

    function void advance_parser(input logic [7:0] b);
      case (phase)
        PhCommand: begin
          if (b == CmdMctp) phase = PhByteCount;
        end
        PhByteCount: begin
          promised = int'(b) - 5;
          if (int'(b) > 5 + PktMtu) too_large = 1'b1;
          phase = PhSource;
        end
        PhSource: phase = PhHeader;
        PhHeader: begin
          // A header byte beyond the fourth is dropped, but still moves on.
          if (hdr_cnt < HdrBytes) begin
            hdr[hdr_cnt] = b;
            hdr_cnt++;
          end
          if (hdr_cnt >= HdrBytes) phase = (promised > 0) ? PhPayload : PhCommand;
        end
        default: begin
          if (pay_cnt < PktMtu) begin
            packet_buf[pay_cnt] = b;
            pay_cnt++;
          end
        end
      endcase
    endfunction

    // Validates the held packet and appends its payload to the message.
    function logic [2:0] close_packet();
      logic [7:0] flags;
      int room;
      int n;
      flags = hdr[3];
      if (too_large) begin
        assembling = 1'b0;
        return StOversize;
      end
      if (pay_cnt < promised) begin
        assembling = 1'b0;
        return StTruncate;
      end
      if (flags[7]) begin
        stored_len = 0;
        exp_seq    = 2'd0;
        assembling = 1'b1;
        held_peer  = hdr[2];
        held_tag   = flags[2:0];
      end else if (!assembling || flags[5:4] != exp_seq) begin
        assembling = 1'b0;
        return StSeqError;
      end
      // The store saturates: payload past its end is silently lost.
      room = MsgBytes - stored_len;
      n = (pay_cnt < room) ? pay_cnt : room;
      for (int i = 0; i < n; i++) store[stored_len + i] = packet_buf[i];
      stored_len += n;
      if (stored_len > written_top) written_top = stored_len;
      exp_seq = exp_seq + 2'd1;
      if (flags[6]) begin
        assembling = 1'b0;
        return StComplete;
      end
      return StFragment;
    endfunction

    function void note_accepted(input logic [1:0] m, input logic [7:0] b,
                                input logic [MsgAw-1:0] idx);
      reassembly_result_t res;
      res = '0;
      case (m)
        ModeStart: begin
          phase     = PhCommand;
          hdr_cnt   = 0;
          pay_cnt   = 0;
          too_large = 1'b0;
        end
        ModeByte: advance_parser(b);
        ModeFinish: begin
          // A finish with a partial header keeps it for the next transfer.
          if (hdr_cnt == HdrBytes) begin
            res.status = close_packet();
            hdr_cnt    = 0;
            pay_cnt    = 0;
            promised   = 0;
          end
          phase = PhCommand;
        end
        default: res.rdata = store[idx];
      endcase
      res.length = MsgLenW'(stored_len);
      res.peer   = held_peer;
      res.tag    = held_tag;
      res.busy   = assembling;
      pending_results.push_back(res);
    endfunction

    task report_mismatch(input string what);
      errors++;
      if (errors <= 40) $display("%0t: mismatch: %s", $time, what);
    endtask

    task check_result(input reassembly_result_t got);
      reassembly_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with nothing outstanding");
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
      if (got.length !== want.length)
        report_mismatch($sformatf("message length %0d, wanted %0d", got.length, want.length));
      if (got.peer !== want.peer)
        report_mismatch($sformatf("peer endpoint %0h, wanted %0h", got.peer, want.peer));
      if (got.tag !== want.tag)
        report_mismatch($sformatf("message tag %0d, wanted %0d", got.tag, want.tag));
      if (got.rdata !== want.rdata)
        report_mismatch($sformatf("read data %0h, wanted %0h", got.rdata, want.rdata));
      if (got.busy !== want.busy)
        report_mismatch($sformatf("in progress %0b, wanted %0b", got.busy, want.busy));
    endtask

    function int pending_count();
      return pending_results.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         mode_i;
  logic [7:0]         data_byte_i;
  logic [MsgAw-1:0]   read_index_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [2:0]         status_o;
  logic [MsgLenW-1:0] message_length_o;
  logic [7:0]         peer_endpoint_o;
  logic [2:0]         message_tag_o;
  logic [7:0]         read_data_o;
  logic               in_progress_o;

  reassembly_scoreboard sb;
  reassembly_result_t   result_seen;
  bit                   gaps_on;
  int                   hold_off_cycles;
  int                   items_sent;

  mctp_smbus_rx_reassembly_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .data_byte_i      (data_byte_i),
    .read_index_i     (read_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .message_length_o (message_length_o),
    .peer_endpoint_o  (peer_endpoint_o),
    .message_tag_o    (message_tag_o),
    .read_data_o      (read_data_o),
    .in_progress_o    (in_progress_o)
  );

  always #4 clk_i = ~clk_i;

  // Result side: ready is redrawn every falling edge. A requested hold-off
  // keeps it low for that many cycles while the sender keeps offering.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(gaps_on && $urandom_range(0, 99) < 16);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_seen.status = status_o;
      result_seen.length = message_length_o;
      result_seen.peer   = peer_endpoint_o;
      result_seen.tag    = message_tag_o;
      result_seen.rdata  = read_data_o;
      result_seen.busy   = in_progress_o;
      sb.check_result(result_seen);
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [MsgAw-1:0] rand_index();
    return MsgAw'($urandom_range(0, MsgBytes - 1));
  endfunction

  // Called just after a falling edge; returns just after the falling edge that
  // follows acceptance, so back-to-back items keep valid high.
  task automatic send_item(input logic [1:0] m, input logic [7:0] b,
                           input logic [MsgAw-1:0] idx);
    while (gaps_on && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    data_byte_i  <= b;
    read_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_accepted(m, b, idx);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(ModeByte, b, rand_index());
  endtask

  // Start or finish, with the unused fields randomized.
  task automatic send_event(input logic [1:0] m);
    send_item(m, rand_byte(), rand_index());
  endtask

  // Reads only positions that some packet has written.
  task automatic read_stored(input int idx);
    if (idx < sb.written_top) send_item(ModeRead, rand_byte(), MsgAw'(idx));
  endtask

  function automatic logic [7:0] make_flags(input bit som, input bit eom,
                                            input logic [1:0] seq, input logic [2:0] tag);
    bit owner;
    owner = 1'($urandom_range(0, 1));
    return {som, eom, seq, owner, tag};
  endfunction

  // One SMBus block write: command, byte count, source address, MCTP header
  // (version, destination, source endpoint, flags) and payload.
  task automatic send_packet(input logic [7:0] count_byte, input logic [7:0] flags,
                             input int n_pay, input bit with_start, input bit with_finish);
    if (with_start) send_event(ModeStart);
    send_byte(CmdMctp);
    send_byte(count_byte);
    send_byte(rand_byte());
    send_byte(rand_byte());
    send_byte(rand_byte());
    send_byte(rand_byte());
    send_byte(flags);
    for (int k = 0; k < n_pay; k++) send_byte(rand_byte());
    if (with_finish) send_event(ModeFinish);
  endtask

  // A message of several packets, mostly well formed; with faults enabled a
  // few packets get a wrong sequence, a bad byte count or a missing start.
  task automatic send_message(input int packets, input int max_pay, input bit faults);
    logic [2:0] tag;
    logic [1:0] seq;
    bit         som;
    bit         with_start;
    int         n;
    int         n_send;
    int         cnt;
    int         fault;
    tag = 3'($urandom_range(0, 7));
    for (int k = 0; k < packets; k++) begin
      seq        = 2'(k % 4);
      som        = (k == 0);
      n          = $urandom_range(0, max_pay);
      n_send     = n;
      cnt        = n + 5;
      with_start = 1'b1;
      fault      = faults ? $urandom_range(0, 99) : 99;
      case (fault)
        0, 1: seq = seq + 2'($urandom_range(1, 3));
        2: som = 1'b0;
        3: cnt = n + 5 + $urandom_range(1, 4);
        4: cnt = $urandom_range(74, 255);
        5: n_send = n + $urandom_range(1, 6);
        6: cnt = $urandom_range(0, 4);
        7: with_start = 1'b0;
        default: ;
      endcase
      send_packet(8'(cnt), make_flags(som, k == packets - 1, seq, tag), n_send,
                  with_start, 1'b1);
    end
  endtask

  task automatic scatter_noise();
    int kind;
    kind = $urandom_range(0, 3);
    case (kind)
      0: send_event(ModeStart);
      1: repeat ($urandom_range(1, 6)) begin
        send_byte(($urandom_range(0, 3) == 0) ? CmdMctp : rand_byte());
      end
      2: send_event(ModeFinish);
      default: send_packet(rand_byte(), rand_byte(), $urandom_range(0, 8),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endcase
  endtask

  initial begin
    #10_000_000;
    $display("mctp_smbus_rx_reassembly_core test failed");
    $finish;
  end

  initial begin
    int         pick;
    int         random_base;
    bit         hold_done;
    sb              = new();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    mode_i          = ModeStart;
    data_byte_i     = 8'd0;
    read_index_i    = '0;
    out_ready_i     = 1'b0;
    gaps_on         = 1'b1;
    hold_off_cycles = 0;
    items_sent      = 0;
    hold_done       = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Finish and a stray byte with nothing open.
    send_event(ModeFinish);
    send_byte(8'h55);

    // Single-packet message carrying the byte extremes, read back.
    send_packet(8'd8, make_flags(1'b1, 1'b1, 2'd0, 3'd7), 0, 1'b1, 1'b0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CmdMctp);
    send_event(ModeFinish);
    read_stored(0);
    read_stored(1);
    read_stored(2);

    // Middle packet with no message open.
    send_packet(8'd6, make_flags(1'b0, 1'b0, 2'd0, 3'd1), 1, 1'b1, 1'b1);

    // Oversized count; the flag survives a later transfer without a start.
    send_packet(8'd74, make_flags(1'b1, 1'b1, 2'd0, 3'd2), 2, 1'b1, 1'b1);
    send_packet(8'd6, make_flags(1'b1, 1'b1, 2'd0, 3'd2), 1, 1'b0, 1'b1);
    send_packet(8'd255, make_flags(1'b1, 1'b0, 2'd0, 3'd2), 3, 1'b1, 1'b1);

    // Truncated: count promises five bytes, three arrive.
    send_packet(8'd10, make_flags(1'b1, 1'b1, 2'd0, 3'd3), 3, 1'b1, 1'b1);

    // Finish after half a header; the next transfer completes the header.
    send_event(ModeStart);
    send_byte(CmdMctp);
    send_byte(8'd7);
    send_byte(8'h20);
    send_byte(8'h01);
    send_byte(8'h08);
    send_event(ModeFinish);
    send_byte(CmdMctp);
    send_byte(8'd7);
    send_byte(8'h20);
    send_byte(8'hA5);
    send_byte(make_flags(1'b1, 1'b1, 2'd0, 3'd4));
    send_byte(8'h3C);
    send_byte(8'hC3);
    send_event(ModeFinish);

    // Header byte arriving while the header is already full.
    send_packet(8'd5, make_flags(1'b1, 1'b1, 2'd0, 3'd6), 0, 1'b1, 1'b0);
    send_byte(CmdMctp);
    send_byte(8'd7);
    send_byte(8'h20);
    send_byte(8'h99);
    send_byte(8'h11);
    send_byte(8'h22);
    send_event(ModeFinish);

    // Surplus payload, and payload past the packet buffer.
    send_packet(8'd6, make_flags(1'b1, 1'b1, 2'd0, 3'd0), 5, 1'b1, 1'b1);
    send_packet(8'd73, make_flags(1'b1, 1'b1, 2'd0, 3'd1), 72, 1'b1, 1'b1);

    // Byte counts of zero and of five, which promise no payload.
    send_packet(8'd0, make_flags(1'b1, 1'b1, 2'd0, 3'd2), 2, 1'b1, 1'b1);
    send_packet(8'd5, make_flags(1'b1, 1'b1, 2'd0, 3'd3), 0, 1'b1, 1'b1);

    // Sequence check: a skipped number aborts, later middles keep failing.
    send_packet(8'd8, make_flags(1'b1, 1'b0, 2'd0, 3'd5), 3, 1'b1, 1'b1);
    send_packet(8'd8, make_flags(1'b0, 1'b0, 2'd1, 3'd5), 3, 1'b1, 1'b1);
    send_packet(8'd8, make_flags(1'b0, 1'b0, 2'd3, 3'd5), 3, 1'b1, 1'b1);
    send_packet(8'd8, make_flags(1'b0, 1'b1, 2'd2, 3'd5), 3, 1'b1, 1'b1);

    // Noise before the command, and a start in the middle of a payload.
    send_event(ModeStart);
    send_byte(8'h0E);
    send_byte(8'hF0);
    send_packet(8'd20, make_flags(1'b1, 1'b0, 2'd0, 3'd6), 5, 1'b0, 1'b0);
    send_packet(8'd7, make_flags(1'b1, 1'b1, 2'd0, 3'd7), 2, 1'b1, 1'b1);
    read_stored(1);

    // Random part: mostly well-formed messages with random content, some
    // reads and some noise, with one stretch free of idling on both sides.
    random_base = items_sent;
    while (items_sent < 1000) begin
      if (!hold_done && items_sent - random_base > 150) begin
        hold_off_cycles = 400;
        hold_done = 1'b1;
      end
      gaps_on = !(items_sent - random_base >= 250 && items_sent - random_base < 400);
      pick = $urandom_range(0, 99);
      if (pick < 70)
        send_message($urandom_range(1, 5), ($urandom_range(0, 9) == 0) ? 68 : 12, 1'b1);
      else if (pick < 85)
        repeat ($urandom_range(1, 4)) read_stored(int'($urandom_range(0, sb.written_top - 1)));
      else
        scatter_noise();
    end
    in_valid_i <= 1'b0;

    while (sb.pending_count() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (sb.errors == 0)
      $display("mctp_smbus_rx_reassembly_core test passed");
    else
      $display("mctp_smbus_rx_reassembly_core test failed");
    $finish;
  end
endmodule

// ===== mctp_smbus_rx_reassembly_core.f =====
rtl/core/mctp_rx_pkg.sv
rtl/core/mctp_rx_datapath.sv
rtl/core/mctp_rx_ctrl.sv
rtl/core/mctp_smbus_rx_reassembly_core.sv
sim/testbench.sv
